/* rtl/core/ssap_pkg.sv */
// Shared types, widths and reset constants for the speed-to-angle polynomial block.
`timescale 1ns / 1ps
`default_nettype none

package ssap_pkg;

	// Field and datapath widths
	localparam int SPEED_W = 16;
	localparam int X_W     = SPEED_W + 1;
	localparam int ACC_W   = 48;
	localparam int ANGLE_W = 8;
	localparam int HALF_W  = ACC_W / 2;

	// Defaults for the top-level parameters
	localparam int SPEED_FRAC_BITS_DEF = 10;
	localparam int COEF_FRAC_BITS_DEF  = 40;
	localparam int ANGLE_MAX_DEF       = 180;

	// Polynomial order: one Horner step per coefficient below the top one
	localparam int COEF_N       = 7;
	localparam int HORNER_STEPS = COEF_N - 1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Coefficient reset values, Q7.40, constant term first
	localparam logic signed [ACC_W-1:0] COEF_RESET [COEF_N] = '{
		48'sd100381780223162,
		48'sd1490008569988,
		-48'sd28310514561,
		-48'sd4144252836,
		48'sd423208318,
		48'sd50057417,
		-48'sd743518
	};

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_MIRROR_SIDE,
		REG_COEF_ZERO,
		REG_COEF_ONE,
		REG_COEF_TWO,
		REG_COEF_THREE,
		REG_COEF_FOUR,
		REG_COEF_FIVE,
		REG_COEF_SIX
	} cfg_reg_t;

	// Operand and running sum carried down the Horner chain
	typedef struct packed {
		logic signed [X_W-1:0]   x;
		logic signed [ACC_W-1:0] acc;
	} horner_t;

endpackage

`default_nettype wire

/* rtl/core/ssap_horner_step.sv */
// One Horner step, acc = sat(floor(acc * x / 2^frac) + coef), over two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none

module ssap_horner_step #(
	parameter int SPEED_FRAC_BITS = ssap_pkg::SPEED_FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output      logic                               in_ready,
	input  wire ssap_pkg::horner_t                  in_data,
	input  wire logic signed [ssap_pkg::ACC_W-1:0]  coef,
	output      logic                               out_valid,
	input  wire logic                               out_ready,
	output      ssap_pkg::horner_t                  out_data
);
	import ssap_pkg::*;

	localparam int PLO_W  = HALF_W + 1 + X_W;
	localparam int PHI_W  = HALF_W + X_W;
	localparam int PROD_W = ACC_W + X_W;
	localparam int SUM_W  = PROD_W + 1;

	logic                      valid_s1;
	logic signed [X_W-1:0]     x_s1;
	logic signed [PLO_W-1:0]   plo_s1;
	logic signed [PHI_W-1:0]   phi_s1;
	logic                      valid_s2;
	horner_t                   data_s2;

	logic                      ready_s1;
	logic                      ready_s2;
	logic signed [PLO_W-1:0]   plo;
	logic signed [PHI_W-1:0]   phi;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_shr;
	logic signed [SUM_W-1:0]   sum;
	logic [SUM_W-ACC_W:0]      sum_top;
	logic signed [ACC_W-1:0]   acc_next;

	// Stall chain: a stage loads when empty or when its successor loads
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Split the accumulator in halves: unsigned low, signed high
	assign plo = $signed({1'b0, in_data.acc[HALF_W-1:0]}) * in_data.x;
	assign phi = $signed(in_data.acc[ACC_W-1:HALF_W]) * in_data.x;

	// Recombine, floor the fraction away, add the coefficient
	assign prod     = (PROD_W'(phi_s1) <<< HALF_W) + PROD_W'(plo_s1);
	assign prod_shr = prod >>> SPEED_FRAC_BITS;
	assign sum      = SUM_W'(prod_shr) + SUM_W'(coef);
	assign sum_top  = sum[SUM_W-1:ACC_W-1];

	// Saturate to the accumulator range
	always_comb begin
		priority if (sum_top == '0 || sum_top == '1) begin
			acc_next = sum[ACC_W-1:0];
		end else if (sum[SUM_W-1]) begin
			acc_next = ACC_MIN;
		end else begin
			acc_next = ACC_MAX;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload, held while stalled
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			x_s1   <= in_data.x;
			plo_s1 <= plo;
			phi_s1 <= phi;
		end
		if (ready_s2 && valid_s1) begin
			data_s2.x   <= x_s1;
			data_s2.acc <= acc_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

`ifndef ASSERT_OFF
	// The operand moves unchanged from the product stage to the sum stage
	a_x_carried: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 |=> valid_s2 && data_s2.x == $past(x_s1))
		else $error("horner step: operand changed between stages");

	// Backpressure only when both stages hold a beat and the sink stalls
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("horner step: input blocked with room in the pipe");

	// A stalled product stage keeps its partial products
	a_products_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(plo_s1) && $stable(phi_s1))
		else $error("horner step: partial products lost under stall");
`endif

endmodule

`default_nettype wire

/* rtl/core/servo_speed_to_angle_poly.sv */
// Servo angle from wheel speed: pipelined degree-6 Horner evaluation with clamp.
//
// Input channel in_valid/in_ready carries speed, signed Q5.10. With
// mirror_side set the curve is evaluated at the negated speed, carried at
// 17 bits so the most negative speed negates exactly.
// Output channel out_valid/out_ready carries angle (0..ANGLE_MAX) and the
// clamped flag, one beat per input beat, in order.
// Configuration channel cfg_valid/cfg_ready writes register cfg_index with
// cfg_data: 0 mirror_side, 1..7 coefficients zero..six (Q7.40). cfg_ready is
// always high. Write only while the pipe is empty.
// Pipeline: the input beat passes through 14
// register stages (the first loads at the accept edge): one entry stage,
// two stages per Horner step (partial products, then recombine, shift, add
// and saturate) for six steps, and one truncate-and-clamp output stage.
// Throughput: one beat per cycle unless the sink stalls; each step splits
// the 48x17 product into two 24-bit halves so no multiplier exceeds 25x17 bits.
// Reset: arst_n clears all valid bits and loads the reset coefficients and
// mirror_side = 0; no clearing pass, the block accepts beats right away.
// Stall: each stage holds its beat while the next one is full and blocked,
// so bubbles close up; in_ready drops only when every stage holds a beat.
`timescale 1ns / 1ps
`default_nettype none

module servo_speed_to_angle_poly #(
	parameter int SPEED_FRAC_BITS = ssap_pkg::SPEED_FRAC_BITS_DEF,
	parameter int COEF_FRAC_BITS  = ssap_pkg::COEF_FRAC_BITS_DEF,
	parameter int ANGLE_MAX       = ssap_pkg::ANGLE_MAX_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output      logic                                  in_ready,
	input  wire logic signed [ssap_pkg::SPEED_W-1:0]   speed,
	output      logic                                  out_valid,
	input  wire logic                                  out_ready,
	output      logic [ssap_pkg::ANGLE_W-1:0]          angle,
	output      logic                                  clamped,
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [2:0]                            cfg_index,
	input  wire logic [ssap_pkg::ACC_W-1:0]            cfg_data
);
	import ssap_pkg::*;

	localparam logic signed [ACC_W-1:0] ANGLE_MAX_ACC = ACC_W'(ANGLE_MAX);

	logic                     mirror_q;
	logic signed [ACC_W-1:0]  coef_q [COEF_N];

	logic                     valid_s1;
	horner_t                  data_s1;
	logic                     ready_s1;
	logic signed [X_W-1:0]    x_in;

	logic                     chain_valid [HORNER_STEPS+1];
	logic                     chain_ready [HORNER_STEPS+1];
	horner_t                  chain_data  [HORNER_STEPS+1];

	logic                     out_valid_q;
	logic [ANGLE_W-1:0]       angle_q;
	logic                     clamped_q;
	logic                     ready_out;

	logic signed [ACC_W-1:0]  acc_fin;
	logic signed [ACC_W-1:0]  ip_floor;
	logic signed [ACC_W-1:0]  ipart;
	logic                     frac_nz;
	logic [ANGLE_W-1:0]       angle_next;
	logic                     clamped_next;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
			for (int i = 0; i < COEF_N; i++) begin
				coef_q[i] <= COEF_RESET[i];
			end
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIRROR_SIDE: begin
					mirror_q <= cfg_data[0];
				end
				default: begin
					coef_q[3'(cfg_index - REG_COEF_ZERO)] <= cfg_data;
				end
			endcase
		end
	end

	// Entry stage: form the operand, seed the sum with the top coefficient
	assign x_in     = mirror_q ? -X_W'(speed) : X_W'(speed);
	assign ready_s1 = !valid_s1 || chain_ready[0];
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			data_s1.x   <= x_in;
			data_s1.acc <= coef_q[COEF_N-1];
		end
	end

	assign chain_valid[0] = valid_s1;
	assign chain_data[0]  = data_s1;

	// Horner chain, highest remaining coefficient first
	for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_step
		ssap_horner_step #(
			.SPEED_FRAC_BITS(SPEED_FRAC_BITS)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[g]),
			.in_ready (chain_ready[g]),
			.in_data  (chain_data[g]),
			.coef     (coef_q[HORNER_STEPS-1-g]),
			.out_valid(chain_valid[g+1]),
			.out_ready(chain_ready[g+1]),
			.out_data (chain_data[g+1])
		);
	end

	// Truncate toward zero: floor, then bump negatives with a fraction
	assign acc_fin  = chain_data[HORNER_STEPS].acc;
	assign ip_floor = acc_fin >>> COEF_FRAC_BITS;
	assign frac_nz  = |acc_fin[COEF_FRAC_BITS-1:0];
	assign ipart    = ip_floor + ACC_W'(acc_fin[ACC_W-1] && frac_nz);

	// Clamp to the servo range
	always_comb begin
		priority if (ipart[ACC_W-1]) begin
			angle_next   = '0;
			clamped_next = 1'b1;
		end else if (ipart > ANGLE_MAX_ACC) begin
			angle_next   = ANGLE_W'(ANGLE_MAX);
			clamped_next = 1'b1;
		end else begin
			angle_next   = ipart[ANGLE_W-1:0];
			clamped_next = 1'b0;
		end
	end

	// Output register
	assign ready_out                 = !out_valid_q || out_ready;
	assign chain_ready[HORNER_STEPS] = ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= chain_valid[HORNER_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && chain_valid[HORNER_STEPS]) begin
			angle_q   <= angle_next;
			clamped_q <= clamped_next;
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;
	assign clamped   = clamped_q;

`ifndef ASSERT_OFF
	// Angle never leaves the servo range
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle <= ANGLE_W'(ANGLE_MAX))
		else $error("servo angle above range");

	// A clamped beat sits on one of the range ends
	a_clamp_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |-> angle == '0 || angle == ANGLE_W'(ANGLE_MAX))
		else $error("clamped beat not at a range end");

	// Input backpressure only when the pipe is full behind a stalled sink
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked while output side moves");
`endif

endmodule

`default_nettype wire
